@@ src/ffa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the first-fit block allocator.
// Used by the channel interfaces, the table cells and the top level.
package ffa_pkg;

  // Payload field widths
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned STATUS_W = 2;

  // Item kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // Configuration port layout
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b0;
  localparam logic [FIELD_W-1:0] HEAP_LIMIT_RST = 16'hFFFF;

  // Probe word that walks the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic                 done;
    logic [FIELD_W-1:0]   size;
    logic [FIELD_W-1:0]   addr;
    logic [FIELD_W-1:0]   grant;
    status_e              status;
  } tok_t;

  // Finished result word
  typedef struct packed {
    logic [FIELD_W-1:0] grant;
    status_e            status;
  } res_t;

endpackage

@@ src/ffa_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on ffa_pkg for the field widths.
interface ffa_req_if;
  import ffa_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FIELD_W-1:0] request_size;
  logic [FIELD_W-1:0] user_address;

  modport source (output valid, kind, request_size, user_address, input ready);
  modport sink   (input valid, kind, request_size, user_address, output ready);
endinterface

interface ffa_rsp_if;
  import ffa_pkg::*;
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  granted_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface

@@ src/ffa_cell.sv @@
`timescale 1ns / 1ps
// One table entry of the allocator: block start, size and free mark.
// Checks the passing probe word against its entry and hands it on. Uses ffa_pkg.
module ffa_cell #(
  parameter int unsigned INDEX        = 0,
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned ADDR_BITS    = 16,
  localparam int unsigned IdxW = $clog2(MAX_BLOCKS),
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffa_pkg::tok_t        tok_i,
  output ffa_pkg::tok_t        tok_o,
  input  logic [CntW-1:0]      count_i,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_idx_i,
  input  logic [ADDR_BITS-1:0] wr_start_i,
  input  logic [ffa_pkg::FIELD_W-1:0] wr_bytes_i
);
  import ffa_pkg::*;

  localparam int unsigned CmpW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 1;
  localparam logic [CntW-1:0] MyCnt = CntW'(INDEX);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(INDEX);

  logic [ADDR_BITS-1:0] start_q;
  logic [FIELD_W-1:0]   bytes_q;
  logic                 free_q, free_d;
  logic [ADDR_BITS:0]   uaddr;
  logic                 ent_valid, fit, addr_eq, hit, wr_me;
  tok_t                 tok_q, tok_d;

  // Match the probe against this entry
  assign ent_valid = count_i > MyCnt;
  assign uaddr     = {1'b0, start_q} + (ADDR_BITS + 1)'(HEADER_BYTES);
  assign addr_eq   = CmpW'(uaddr) == CmpW'(tok_i.addr);
  assign fit       = free_q && (bytes_q >= tok_i.size);
  assign hit       = tok_i.valid && !tok_i.done && ent_valid &&
                     ((tok_i.kind == KIND_ALLOC) ? fit : addr_eq);
  assign wr_me     = wr_en_i && (wr_idx_i == MyIdx);

  // Claim the probe on a hit, else pass it unchanged
  always_comb begin
    tok_d  = tok_i;
    free_d = free_q;
    if (hit) begin
      tok_d.done   = 1'b1;
      tok_d.status = ST_OK;
      if (tok_i.kind == KIND_ALLOC) begin
        tok_d.grant = FIELD_W'(uaddr[ADDR_BITS-1:0]);
        free_d      = 1'b0;
      end else begin
        tok_d.grant = '0;
        free_d      = 1'b1;
      end
    end
    if (wr_me) begin
      free_d = 1'b0;
    end
  end

  // Control: free mark and the probe stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      free_q <= free_d;
      tok_q  <= tok_d;
    end
  end

  // Payload: entry written on append
  always_ff @(posedge clk_i) begin
    if (wr_me) begin
      start_q <= wr_start_i;
      bytes_q <= wr_bytes_i;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ src/first_fit_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// First-fit block allocator: a row of MAX_BLOCKS table cells walked by a probe word,
// with the sequencer, heap top and configuration register. Uses ffa_pkg, ffa_if, ffa_cell.
//
// Usage:
//   req_i carries one word per item: kind (0 allocate, 1 free), request_size and
//   user_address. rsp_o returns exactly one word per item: granted_address and status
//   (0 ok, 1 zero size or null, 2 heap or table exhausted, 3 unknown address).
//   heap_limit sits at byte address 0 of the APB port; write it only while idle.
// Flow:
//   An accepted word is loaded as a probe into the injection register and steps
//   through the MAX_BLOCKS cell registers, one cell per cycle. The end of the walk
//   decides on append and writes the result into the pending register, which moves
//   into the output register once that register is free. One word is in flight at
//   a time; the next one is taken once the response is parked in the output register,
//   so the block never takes a new word before it is through with the last one.
// Reset:
//   Clears the free marks, block count, heap top and the probe chain, and sets
//   heap_limit to 0xFFFF. Table contents need no clearing pass.
// Stall:
//   A stalled response holds in the output register; the block accepts one more word
//   and then waits with that result until the output register drains.
module first_fit_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned ADDR_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffa_req_if.sink                       req_i,
  ffa_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffa_pkg::PADDR_W-1:0]   paddr,
  input  logic [ffa_pkg::PDATA_W-1:0]   pwdata,
  output logic [ffa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ffa_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EndW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 2;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);
  localparam logic [EndW-1:0] AddrMax = {{(EndW - ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  tok_t                  inj_q, inj_d;
  res_t                  pend_q, pend_d, out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [ADDR_BITS:0]    top_q, top_d;
  logic [FIELD_W-1:0]    heap_limit_q;
  logic                  wr_en;
  logic [EndW-1:0]       end_sum, end_m1, top_user;
  logic                  accept;
  logic [REG_IDX_W-1:0]  reg_idx;
  tok_t                  chain [MAX_BLOCKS+1];
  tok_t                  ret;
  logic [MAX_BLOCKS:0]   tok_vld;

  // Configuration register
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_HEAP_LIMIT) ? PDATA_W'(heap_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= HEAP_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_HEAP_LIMIT)) begin
      heap_limit_q <= pwdata[FIELD_W-1:0];
    end
  end

  // Cell chain
  assign chain[0] = inj_q;
  assign ret      = chain[MAX_BLOCKS];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffa_cell #(
      .INDEX        (k),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES),
      .ADDR_BITS    (ADDR_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (chain[k]),
      .tok_o      (chain[k+1]),
      .count_i    (cnt_q),
      .wr_en_i    (wr_en),
      .wr_idx_i   (cnt_q[IdxW-1:0]),
      .wr_start_i (top_q[ADDR_BITS-1:0]),
      .wr_bytes_i (ret.size)
    );
  end

  for (genvar k = 0; k <= MAX_BLOCKS; k++) begin : g_vld
    assign tok_vld[k] = chain[k].valid;
  end

  // Append arithmetic on the returning probe
  assign end_sum  = EndW'(top_q) + EndW'(HEADER_BYTES) + EndW'(ret.size);
  assign end_m1   = end_sum - EndW'(1);
  assign top_user = EndW'(top_q) + EndW'(HEADER_BYTES);

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    inj_d       = inj_q;
    inj_d.valid = 1'b0;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    cnt_d       = cnt_q;
    top_d       = top_q;
    wr_en       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          inj_d.valid = 1'b1;
          inj_d.kind  = req_i.kind;
          inj_d.size  = req_i.request_size;
          inj_d.addr  = req_i.user_address;
          inj_d.grant = '0;
          inj_d.done  = (req_i.kind == KIND_ALLOC) ? (req_i.request_size == '0)
                                                   : (req_i.user_address == '0);
          inj_d.status = inj_d.done ? ST_NULL : ST_OK;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ret.valid) begin
          state_d = S_DONE;
          if (ret.done) begin
            pend_d.grant  = ret.grant;
            pend_d.status = ret.status;
          end else if (ret.kind == KIND_FREE) begin
            pend_d.grant  = '0;
            pend_d.status = ST_UNKNOWN;
          end else if ((cnt_q == CntMax) || (end_m1 > EndW'(heap_limit_q)) ||
                       (end_m1 > AddrMax)) begin
            pend_d.grant  = '0;
            pend_d.status = ST_FULL;
          end else begin
            // Append a new block at the heap top
            wr_en         = 1'b1;
            pend_d.grant  = FIELD_W'(top_user[ADDR_BITS-1:0]);
            pend_d.status = ST_OK;
            cnt_d         = cnt_q + CntW'(1);
            top_d         = end_sum[ADDR_BITS:0];
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inj_q       <= '0;
      pend_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      top_q       <= '0;
    end else begin
      state_q     <= state_d;
      inj_q       <= inj_d;
      pend_q      <= pend_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      top_q       <= top_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.granted_address = out_q.grant;
  assign rsp_o.status          = out_q.status;

  // Checks
  a_one_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one probe word in the chain");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("block count beyond table size");

  a_ret_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret.valid |-> state_q == S_SCAN)
    else $error("probe returned outside of a scan");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("append did not advance the block count");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != ST_OK) |-> out_q.grant == '0)
    else $error("failed result carries a nonzero address");

endmodule

@@ bench/first_fit_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for first_fit_block_allocator_unit: request words, a scoreboard
// that tracks the block table, and heap_limit set over the APB port.
// Depends on ffa_pkg, the channel interfaces in ffa_if and the allocator RTL.
module first_fit_block_allocator_unit_tb;
  import ffa_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned HDR         = 24;
  localparam int unsigned ADDR_SPAN   = 65536;

  // Tracks the block table and the words still owed by the allocator
  class alloc_scoreboard;
    logic [FIELD_W-1:0] blk_start [TABLE_DEPTH];
    logic [FIELD_W-1:0] blk_bytes [TABLE_DEPTH];
    bit                 blk_free  [TABLE_DEPTH];
    int unsigned        block_count;
    int unsigned        heap_top;
    logic [FIELD_W-1:0] heap_limit;
    res_t               owed[$];
    int unsigned        fails;

    function new();
      foreach (blk_free[i]) blk_free[i] = 1'b0;
      block_count = 0;
      heap_top    = 0;
      heap_limit  = HEAP_LIMIT_RST;
      fails       = 0;
    endfunction

    function void flag(string what);
      fails++;
      if (fails <= 10) $display("%0t: mismatch: %s", $realtime, what);
    endfunction

    function logic [FIELD_W-1:0] user_addr(int unsigned idx);
      return 16'(blk_start[idx] + HDR);
    endfunction

    function int unsigned free_blocks();
      int unsigned cnt;
      cnt = 0;
      for (int unsigned i = 0; i < block_count; i++) if (blk_free[i]) cnt++;
      return cnt;
    endfunction

    // First fit over the table, else append at the heap top
    function res_t grant_block(logic [FIELD_W-1:0] size);
      res_t        r;
      int unsigned tail;
      r.grant  = '0;
      r.status = ST_NULL;
      if (size == 0) return r;
      for (int unsigned i = 0; i < block_count; i++) begin
        if (blk_free[i] && blk_bytes[i] >= size) begin
          blk_free[i] = 1'b0;
          r.grant     = user_addr(i);
          r.status    = ST_OK;
          return r;
        end
      end
      r.status = ST_FULL;
      if (block_count >= TABLE_DEPTH) return r;
      tail = heap_top + HDR + size;
      if (tail - 1 > heap_limit || tail - 1 > ADDR_SPAN - 1) return r;
      blk_start[block_count] = 16'(heap_top);
      blk_bytes[block_count] = size;
      blk_free[block_count]  = 1'b0;
      r.grant  = user_addr(block_count);
      r.status = ST_OK;
      block_count++;
      heap_top = tail;
      return r;
    endfunction

    // Mark the block with this user address free
    function res_t release_block(logic [FIELD_W-1:0] addr);
      res_t r;
      r.grant  = '0;
      r.status = ST_NULL;
      if (addr == 0) return r;
      for (int unsigned i = 0; i < block_count; i++) begin
        if (user_addr(i) == addr) begin
          blk_free[i] = 1'b1;
          r.status    = ST_OK;
          return r;
        end
      end
      r.status = ST_UNKNOWN;
      return r;
    endfunction

    function void note_request(logic k, logic [FIELD_W-1:0] sz, logic [FIELD_W-1:0] ua);
      if (k == KIND_ALLOC) owed.push_back(grant_block(sz));
      else owed.push_back(release_block(ua));
    endfunction

    function void check_response(logic [FIELD_W-1:0] grant, logic [STATUS_W-1:0] status);
      res_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected word grant=%0d status=%0d", grant, status));
        return;
      end
      want = owed.pop_front();
      if (grant !== want.grant)
        flag($sformatf("granted_address exp %0d got %0d", want.grant, grant));
      if (status !== want.status)
        flag($sformatf("status exp %0d got %0d", want.status, status));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  ffa_req_if req_if ();
  ffa_rsp_if rsp_if ();

  alloc_scoreboard sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_len;
  int unsigned hold_left  = 0;
  bit          hold_taken = 1'b0;

  first_fit_block_allocator_unit #(
    .MAX_BLOCKS  (TABLE_DEPTH),
    .HEADER_BYTES(HDR),
    .ADDR_BITS   (16)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // Drive the response ready: long hold first, else random stalls
  always @(negedge clk_i) begin
    if (hold_len != 0 && !hold_taken) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_len - 1;
      hold_taken   <= 1'b1;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every response word taken
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.granted_address, rsp_if.status);
  end

  // Write heap_limit, then read it back
  task automatic set_heap_limit(input logic [FIELD_W-1:0] v);
    logic [PDATA_W-1:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_HEAP_LIMIT, 2'b00};
    pwdata  <= {16'h0000, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.heap_limit = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[FIELD_W-1:0] !== v)
      sb.flag($sformatf("heap_limit readback exp %0d got %0d", v, rd[FIELD_W-1:0]));
  endtask

  // Offer one request word, with random idle cycles ahead of it
  task automatic send_word(input logic k, input logic [FIELD_W-1:0] sz,
                           input logic [FIELD_W-1:0] ua);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= k;
    req_if.request_size <= sz;
    req_if.user_address <= ua;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(k, sz, ua);
  endtask

  // Drop valid and hold until every owed word has come back
  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // Mostly allocations and frees of live blocks, some null and stray addresses
  task automatic send_random(input bit wide_sizes);
    int unsigned        r;
    int unsigned        t;
    logic [FIELD_W-1:0] sz;
    logic [FIELD_W-1:0] ua;
    r  = $urandom_range(99);
    sz = 16'($urandom);
    ua = 16'($urandom);
    if (r < 52) begin
      t = $urandom_range(99);
      if (t < 60) sz = 16'($urandom_range(64, 1));
      else if (t < 90 || !wide_sizes) sz = 16'($urandom_range(512, 1));
      send_word(KIND_ALLOC, sz, ua);
    end else if (r < 92 && sb.block_count > 0) begin
      send_word(KIND_FREE, sz, sb.user_addr($urandom_range(sb.block_count - 1)));
    end else begin
      case ($urandom_range(2))
        0:       send_word(KIND_ALLOC, 16'h0000, ua);
        1:       send_word(KIND_FREE, sz, 16'h0000);
        default: send_word(KIND_FREE, sz, ua);
      endcase
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned lim;
    int unsigned top_size;
    int unsigned phase_len [6];

    phase_len = '{250, 250, 300, 300, 250, 250};
    sb        = new();
    idle_pct  = 0;
    stall_pct = 0;
    hold_len  = 0;
    rst_ni    = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_ALLOC;
    req_if.request_size = '0;
    req_if.user_address = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero limit: every append fails, null and unknown cases
    set_heap_limit(16'h0000);
    send_word(KIND_ALLOC, 16'd1, 16'hFFFF);
    send_word(KIND_ALLOC, 16'hFFFF, 16'h0000);
    send_word(KIND_ALLOC, 16'h0000, 16'h1234);
    send_word(KIND_FREE, 16'hFFFF, 16'h0000);
    send_word(KIND_FREE, 16'h0000, 16'hFFFF);
    wait_idle();

    // Full limit: append, exhaustion, double free, reuse by first fit
    set_heap_limit(16'hFFFF);
    send_word(KIND_ALLOC, 16'd1, 16'h0000);
    send_word(KIND_ALLOC, 16'hFFFF, 16'h0000);
    send_word(KIND_ALLOC, 16'd100, 16'h0000);
    send_word(KIND_FREE, 16'h0000, 16'd24);
    send_word(KIND_FREE, 16'h0000, 16'd24);
    send_word(KIND_FREE, 16'h0000, 16'd25);
    send_word(KIND_ALLOC, 16'd2, 16'h0000);
    send_word(KIND_ALLOC, 16'd1, 16'h0000);
    send_word(KIND_FREE, 16'h0000, 16'd49);
    send_word(KIND_ALLOC, 16'd50, 16'h0000);
    send_word(KIND_FREE, 16'h0000, 16'h8000);
    send_word(KIND_ALLOC, 16'h0000, 16'h0000);
    send_word(KIND_FREE, 16'h0000, 16'h0000);

    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph == 2) begin
        // Use up free blocks, grow to one short of full, then end the heap exactly
        set_heap_limit(16'hFFFF);
        idle_pct  = 0;
        stall_pct = 0;
        if (sb.block_count < TABLE_DEPTH) begin
          repeat (sb.free_blocks() + TABLE_DEPTH - 1 - sb.block_count)
            send_word(KIND_ALLOC, 16'd1, 16'($urandom));
          wait_idle();
          top_size = ADDR_SPAN - sb.heap_top - HDR;
          send_word(KIND_ALLOC, 16'(top_size), 16'($urandom));
        end
        // Table full with nothing that fits, then reuse of the top block
        send_word(KIND_ALLOC, 16'd1, 16'($urandom));
        send_word(KIND_FREE, 16'($urandom), sb.user_addr(TABLE_DEPTH - 1));
        send_word(KIND_ALLOC, 16'hFFFF, 16'($urandom));
        send_word(KIND_ALLOC, sb.blk_bytes[TABLE_DEPTH - 1], 16'($urandom));
        send_word(KIND_FREE, 16'($urandom), sb.user_addr(TABLE_DEPTH - 1));
        wait_idle();
      end
      case (ph)
        0: begin
          set_heap_limit(16'hFFFF);
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          lim = sb.heap_top + 1500;
          set_heap_limit(lim > 65535 ? 16'hFFFF : 16'(lim));
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          set_heap_limit(16'($urandom));
          idle_pct  = 0;
          stall_pct = 55;
          hold_len  = 400;
        end
        3: begin
          set_heap_limit(16'h0000);
          idle_pct  = 6;
          stall_pct = 6;
        end
        4: begin
          set_heap_limit(16'($urandom));
          idle_pct  = 55;
          stall_pct = 0;
        end
        default: begin
          set_heap_limit(16'hFFFF);
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      for (n = 0; n < phase_len[ph]; n++) begin
        // Keep room in the table for the exact heap fill
        if (ph == 0 && sb.block_count >= 48) break;
        if (ph == 1 && sb.block_count >= 58) break;
        if (ph == 4 && n == 120) wait_idle();
        send_random(ph != 0);
      end
    end

    // Let the pipeline settle and catch any stray word
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (sb.fails == 0 && sb.owed.size() == 0) begin
      $display("first_fit_block_allocator_unit_tb passed");
    end else begin
      $display("first_fit_block_allocator_unit_tb failed");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule
  initial begin
    #10_000_000;
    $display("first_fit_block_allocator_unit_tb failed");
    $finish;
  end

endmodule

@@ first_fit_block_allocator_unit.f @@
src/ffa_pkg.sv
src/ffa_if.sv
src/ffa_cell.sv
src/first_fit_block_allocator_unit.sv
bench/first_fit_block_allocator_unit_tb.sv
